@@ hdl/scpid_pkg.sv @@
// Shared constants, field layout and saturation helper for the swerve cascaded PID block.
package scpid_pkg;

  // Field widths
  localparam int UNIT_W     = 2;
  localparam int STICK_W    = 8;
  localparam int DT_W       = 16;
  localparam int ANGLE_W    = 9;
  localparam int RPM_W      = 16;
  localparam int VAL_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int LIM_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Input tdata layout, lowest field first
  localparam int IN_FWD_LSB  = 0;
  localparam int IN_TURN_LSB = IN_FWD_LSB + STICK_W;
  localparam int IN_DT_LSB   = IN_TURN_LSB + STICK_W;
  localparam int IN_MOD_LSB  = IN_DT_LSB + DT_W;
  localparam int IN_REF_LSB  = IN_MOD_LSB + ANGLE_W;
  localparam int IN_RPMA_LSB = IN_REF_LSB + ANGLE_W;
  localparam int IN_RPMB_LSB = IN_RPMA_LSB + RPM_W;
  localparam int IN_BITS     = IN_RPMB_LSB + RPM_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 3 * VAL_W;

  localparam int UNITS_DEF = 4;
  localparam int UNIT_MAX  = (1 << UNIT_W) - 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_LIM = 3'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0] SPEED_KP_RST = 32'd218103808;
  localparam logic [GAIN_W-1:0] SPEED_KI_RST = 32'd503316;
  localparam logic [GAIN_W-1:0] SPEED_KD_RST = 32'd838861;
  localparam logic [GAIN_W-1:0] ANGLE_KP_RST = 32'd33554432;
  localparam logic [GAIN_W-1:0] ANGLE_KI_RST = 32'd5033;
  localparam logic [GAIN_W-1:0] ANGLE_KD_RST = 32'd0;
  localparam logic [LIM_W-1:0]  CUR_LIM_RST  = 15'd3000;
  localparam logic [LIM_W-1:0]  CORR_LIM_RST = 15'd60;

  // Stick mapping: (v + 127) * 300 / 127 - 300 and (v + 127) * 100 / 127 - 100
  localparam int DEADBAND       = 12;
  localparam int MAP_BIAS       = 127;
  localparam int MAP_DIV        = 127;
  localparam int MAP_FWD_SCALE  = 300;
  localparam int MAP_TURN_SCALE = 100;
  localparam int MAP_FWD_OFS    = 300;
  localparam int MAP_TURN_OFS   = 100;
  localparam int MAP_RECIP_SH   = 16;
  localparam int MAP_RECIP      = (1 << MAP_RECIP_SH) / MAP_DIV;
  localparam int MAP_X_W        = 17;
  localparam int MAP_Q_W        = 10;
  localparam int MAP_VAL_W      = 10;

  // Shared multiplier and PID arithmetic
  localparam int MUL_A_W   = GAIN_W + 1;
  localparam int MUL_B_W   = VAL_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int FRAC_BITS = 24;
  localparam int PIDQ_W    = PROD_W - FRAC_BITS;
  localparam int SAT_W     = 34;
  localparam int DIV_STEPS = DT_W;

  // Loop selector codes
  localparam logic [1:0] PID_ANGLE = 2'd0;
  localparam logic [1:0] PID_MOT_A = 2'd1;
  localparam logic [1:0] PID_MOT_B = 2'd2;

  typedef logic signed [VAL_W-1:0] s16_t;

  function automatic s16_t sat16(input logic signed [SAT_W-1:0] v);
    s16_t r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/swerve_module_cascaded_pid.sv @@
// Cascaded angle and speed PID controller for one swerve wheel module per beat.
//
// Each input beat (one wheel module, one control tick) yields one output beat with
// the two clamped drive currents and the clamped angle correction. The block works
// on one beat at a time through a single shared 33x17 multiplier and a 16-step
// restoring divider: the stick mapping, then the angle PID update and the two speed
// PID updates, each using the divider for the derivative unless dt_ms is zero. A new
// beat is taken only once the previous result has moved to the output register.
// A finished result waits in the output register while the next beat is processed;
// it must be taken before the following result can leave. PID state is held per
// module in flip-flops and cleared by reset. Configuration writes are always ready.
module swerve_module_cascaded_pid #(
  parameter int UNITS = scpid_pkg::UNITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // stick_fwd, stick_turn, dt_ms, module_angle, reference_angle, rpm_a, rpm_b, zero pad
  input  logic [scpid_pkg::IN_DATA_W-1:0]   in_tdata,
  // unit
  input  logic [scpid_pkg::UNIT_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // current_a, current_b, angle_correction
  output logic [scpid_pkg::OUT_DATA_W-1:0]  out_tdata,
  // unit_out
  output logic [scpid_pkg::UNIT_W-1:0]      out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scpid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scpid_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scpid_pkg::*;

  localparam int AIW   = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int SIW   = $clog2(2 * UNITS);
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [4:0] UNITS_V = 5'(UNITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAP0 = 4'd1;
  localparam logic [3:0] S_MAP1 = 4'd2;
  localparam logic [3:0] S_MAP2 = 4'd3;
  localparam logic [3:0] S_MAP3 = 4'd4;
  localparam logic [3:0] S_INT  = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_M0   = 4'd8;
  localparam logic [3:0] S_M1   = 4'd9;
  localparam logic [3:0] S_M2   = 4'd10;
  localparam logic [3:0] S_M3   = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;
  localparam logic [3:0] S_TGT  = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  localparam logic signed [STICK_W-1:0] DB_POS = 8'(DEADBAND);
  localparam logic signed [STICK_W-1:0] DB_NEG = -8'(DEADBAND);

  // Control state
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             map_turn_r;
  logic [1:0]       pid_sel_r;
  logic             out_valid_r;

  // Configuration
  logic [GAIN_W-1:0] speed_kp_r, speed_ki_r, speed_kd_r;
  logic [GAIN_W-1:0] angle_kp_r, angle_ki_r, angle_kd_r;
  logic [LIM_W-1:0]  cur_lim_r, corr_lim_r;

  // Captured beat and intermediate values
  logic [AIW-1:0]               uidx_r;
  logic [UNIT_W-1:0]            unit_r;
  logic signed [STICK_W-1:0]    stick_fwd_r, stick_turn_r;
  logic [DT_W-1:0]              dt_r;
  logic signed [RPM_W-1:0]      rpm_a_r, rpm_b_r;
  s16_t                         err_r, err_b_r, integ_r;
  s16_t                         corr_r, cur_a_r, cur_b_r;
  logic signed [MAP_VAL_W-1:0]  fwd_r, turn_r;
  logic [MAP_X_W-1:0]           x_r;
  logic [MAP_Q_W-1:0]           q0_r;
  logic signed [PROD_W-1:0]     prod_r, acc_r;
  logic [DT_W-1:0]              quo_r, rem_r, quo_nxt, rem_nxt;
  logic                         dneg_r;

  // Output register
  s16_t              out_cur_a_r, out_cur_b_r, out_corr_r;
  logic [UNIT_W-1:0] out_unit_r;

  // Per-module PID state
  s16_t ang_int_r  [UNITS];
  s16_t ang_prev_r [UNITS];
  s16_t spd_int_r  [2*UNITS];
  s16_t spd_prev_r [2*UNITS];

  // Combinational
  logic                         in_fire, out_load;
  logic [4:0]                   unit_mod;
  logic signed [ANGLE_W:0]      ang_err;
  logic [SIW-1:0]               sidx;
  s16_t                         int_rd, prev_rd, integ_nxt, deriv;
  logic signed [STICK_W-1:0]    stick_sel, stick_db;
  logic signed [STICK_W:0]      map_n, map_abs;
  logic [15:0]                  map_scale, map_ofs;
  logic [MAP_X_W-1:0]           map_r;
  logic [MAP_Q_W-1:0]           map_q;
  logic signed [MAP_VAL_W:0]    map_val;
  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [VAL_W:0]        dnum, dmag;
  logic [DT_W:0]                trial;
  logic                         ge;
  logic [GAIN_W-1:0]            kp_sel, ki_sel, kd_sel;
  logic [LIM_W-1:0]             lim_sel;
  logic signed [PIDQ_W-1:0]     pid_q, lim_q, nlim_q;
  s16_t                         pid_out, tgt_a, tgt_b, err_a_nxt, err_b_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_corr_r, out_cur_b_r, out_cur_a_r};
  assign out_tuser  = out_unit_r;

  // Fold the unit number into range by repeated subtraction
  always_comb begin
    unit_mod = 5'(in_tuser);
    for (int i = 0; i < UNIT_MAX; i++) begin
      if (unit_mod >= UNITS_V) begin
        unit_mod = unit_mod - UNITS_V;
      end
    end
  end

  assign ang_err = $signed({1'b0, in_tdata[IN_REF_LSB +: ANGLE_W]})
                 - $signed({1'b0, in_tdata[IN_MOD_LSB +: ANGLE_W]});

  // State store read port
  assign sidx    = SIW'({uidx_r, pid_sel_r == PID_MOT_B});
  assign int_rd  = (pid_sel_r == PID_ANGLE) ? ang_int_r[uidx_r]  : spd_int_r[sidx];
  assign prev_rd = (pid_sel_r == PID_ANGLE) ? ang_prev_r[uidx_r] : spd_prev_r[sidx];
  assign integ_nxt = sat16(SAT_W'(int_rd) + SAT_W'(prod_r));

  // Stick deadband and mapping operands
  assign stick_sel = map_turn_r ? stick_turn_r : stick_fwd_r;
  assign stick_db  = (stick_sel <= DB_POS && stick_sel >= DB_NEG) ? '0 : stick_sel;
  assign map_n     = 9'(stick_db) + 9'sd127;
  assign map_abs   = map_n[STICK_W] ? -map_n : map_n;
  assign map_scale = map_turn_r ? 16'(MAP_TURN_SCALE) : 16'(MAP_FWD_SCALE);
  assign map_ofs   = map_turn_r ? 16'(MAP_TURN_OFS) : 16'(MAP_FWD_OFS);
  // Reciprocal estimate is exact or one short; fix with one compare
  assign map_r     = x_r - prod_r[MAP_X_W-1:0];
  assign map_q     = q0_r + MAP_Q_W'(map_r >= MAP_X_W'(MAP_DIV));
  assign map_val   = (map_n[STICK_W] ? -$signed({1'b0, map_q}) : $signed({1'b0, map_q}))
                   - $signed(11'(map_ofs));

  // Gain and limit selection
  assign kp_sel  = (pid_sel_r == PID_ANGLE) ? angle_kp_r : speed_kp_r;
  assign ki_sel  = (pid_sel_r == PID_ANGLE) ? angle_ki_r : speed_ki_r;
  assign kd_sel  = (pid_sel_r == PID_ANGLE) ? angle_kd_r : speed_kd_r;
  assign lim_sel = (pid_sel_r == PID_ANGLE) ? corr_lim_r : cur_lim_r;

  // Derivative from the divider result
  assign deriv = (dt_r == '0) ? '0
               : sat16(dneg_r ? -SAT_W'(quo_r) : SAT_W'(quo_r));

  // Shared multiplier
  always_comb begin
    unique case (state_r)
      S_MAP0: begin
        mul_a = MUL_A_W'(map_abs[STICK_W-1:0]);
        mul_b = {1'b0, map_scale};
      end
      S_MAP1: begin
        mul_a = MUL_A_W'(prod_r[MAP_X_W-1:0]);
        mul_b = MUL_B_W'(MAP_RECIP);
      end
      S_MAP2: begin
        mul_a = MUL_A_W'(prod_r[MAP_RECIP_SH +: MAP_Q_W]);
        mul_b = MUL_B_W'(MAP_DIV);
      end
      S_INT: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = {1'b0, dt_r};
      end
      S_M0: begin
        mul_a = {1'b0, kp_sel};
        mul_b = MUL_B_W'(err_r);
      end
      S_M1: begin
        mul_a = {1'b0, ki_sel};
        mul_b = MUL_B_W'(integ_r);
      end
      S_M2: begin
        mul_a = {1'b0, kd_sel};
        mul_b = MUL_B_W'(deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Divider: numerator magnitude and one restoring step
  assign dnum    = MUL_B_W'(err_r) - MUL_B_W'(prev_rd);
  assign dmag    = dnum[VAL_W] ? -dnum : dnum;
  assign trial   = {rem_r, quo_r[DT_W-1]};
  assign ge      = trial >= {1'b0, dt_r};
  assign rem_nxt = ge ? DT_W'(trial - {1'b0, dt_r}) : trial[DT_W-1:0];
  assign quo_nxt = {quo_r[DT_W-2:0], ge};

  // Scale down by 2^24 toward zero, then clamp
  assign pid_q  = PIDQ_W'(acc_r >>> FRAC_BITS)
                + PIDQ_W'(acc_r[PROD_W-1] && (acc_r[FRAC_BITS-1:0] != '0));
  assign lim_q  = $signed(PIDQ_W'(lim_sel));
  assign nlim_q = -lim_q;
  always_comb begin
    priority if (pid_q > lim_q) begin
      pid_out = VAL_W'(lim_q);
    end else if (pid_q < nlim_q) begin
      pid_out = VAL_W'(nlim_q);
    end else begin
      pid_out = VAL_W'(pid_q);
    end
  end

  // Speed targets and errors
  assign tgt_a     = sat16(SAT_W'(fwd_r) - SAT_W'(turn_r) - SAT_W'(corr_r));
  assign tgt_b     = sat16(-SAT_W'(fwd_r) - SAT_W'(turn_r) - SAT_W'(corr_r));
  assign err_a_nxt = sat16(SAT_W'(tgt_a) - SAT_W'(rpm_a_r));
  assign err_b_nxt = sat16(SAT_W'(tgt_b) - SAT_W'(rpm_b_r));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_MAP0;
      S_MAP0: state_nxt = S_MAP1;
      S_MAP1: state_nxt = S_MAP2;
      S_MAP2: state_nxt = S_MAP3;
      S_MAP3: state_nxt = map_turn_r ? S_INT : S_MAP0;
      S_INT:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (dt_r == '0) ? S_M0 : S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_FIN;
      S_FIN: begin
        if (pid_sel_r == PID_ANGLE) begin
          state_nxt = S_TGT;
        end else if (pid_sel_r == PID_MOT_A) begin
          state_nxt = S_INT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_TGT:  state_nxt = S_INT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      map_turn_r  <= 1'b0;
      pid_sel_r   <= PID_ANGLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) map_turn_r <= 1'b0;
      else if (state_r == S_MAP3) map_turn_r <= 1'b1;
      if (state_r == S_MAP3 && map_turn_r) pid_sel_r <= PID_ANGLE;
      else if (state_r == S_TGT) pid_sel_r <= PID_MOT_A;
      else if (state_r == S_FIN && pid_sel_r == PID_MOT_A) pid_sel_r <= PID_MOT_B;
      if (state_r == S_INT) cnt_r <= '0;
      else if (state_r == S_DIV) cnt_r <= cnt_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_kp_r <= SPEED_KP_RST;
      speed_ki_r <= SPEED_KI_RST;
      speed_kd_r <= SPEED_KD_RST;
      angle_kp_r <= ANGLE_KP_RST;
      angle_ki_r <= ANGLE_KI_RST;
      angle_kd_r <= ANGLE_KD_RST;
      cur_lim_r  <= CUR_LIM_RST;
      corr_lim_r <= CORR_LIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED_KP: speed_kp_r <= cfg_data;
        REG_SPEED_KI: speed_ki_r <= cfg_data;
        REG_SPEED_KD: speed_kd_r <= cfg_data;
        REG_ANGLE_KP: angle_kp_r <= cfg_data;
        REG_ANGLE_KI: angle_ki_r <= cfg_data;
        REG_ANGLE_KD: angle_kd_r <= cfg_data;
        REG_CUR_LIM:  cur_lim_r  <= cfg_data[LIM_W-1:0];
        REG_CORR_LIM: corr_lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // PID state stores: write prev error in S_INT, integral in S_ACC
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < UNITS; i++) begin
        ang_int_r[i]  <= '0;
        ang_prev_r[i] <= '0;
      end
      for (int i = 0; i < 2 * UNITS; i++) begin
        spd_int_r[i]  <= '0;
        spd_prev_r[i] <= '0;
      end
    end else begin
      if (state_r == S_INT) begin
        if (pid_sel_r == PID_ANGLE) ang_prev_r[uidx_r] <= err_r;
        else spd_prev_r[sidx] <= err_r;
      end
      if (state_r == S_ACC) begin
        if (pid_sel_r == PID_ANGLE) ang_int_r[uidx_r] <= integ_nxt;
        else spd_int_r[sidx] <= integ_nxt;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (in_fire) begin
      uidx_r       <= AIW'(unit_mod);
      unit_r       <= unit_mod[UNIT_W-1:0];
      stick_fwd_r  <= in_tdata[IN_FWD_LSB +: STICK_W];
      stick_turn_r <= in_tdata[IN_TURN_LSB +: STICK_W];
      dt_r         <= in_tdata[IN_DT_LSB +: DT_W];
      rpm_a_r      <= in_tdata[IN_RPMA_LSB +: RPM_W];
      rpm_b_r      <= in_tdata[IN_RPMB_LSB +: RPM_W];
      err_r        <= VAL_W'(ang_err);
    end
    unique case (state_r)
      S_MAP1: x_r  <= prod_r[MAP_X_W-1:0];
      S_MAP2: q0_r <= prod_r[MAP_RECIP_SH +: MAP_Q_W];
      S_MAP3: begin
        if (map_turn_r) turn_r <= map_val[MAP_VAL_W-1:0];
        else fwd_r <= map_val[MAP_VAL_W-1:0];
      end
      S_INT: begin
        quo_r  <= dmag[DT_W-1:0];
        rem_r  <= '0;
        dneg_r <= dnum[VAL_W];
      end
      S_ACC: integ_r <= integ_nxt;
      S_DIV: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end
      S_M1: acc_r <= prod_r;
      S_M2: acc_r <= acc_r + prod_r;
      S_M3: acc_r <= acc_r + prod_r;
      S_FIN: begin
        if (pid_sel_r == PID_ANGLE) begin
          corr_r <= pid_out;
        end else if (pid_sel_r == PID_MOT_A) begin
          cur_a_r <= pid_out;
          err_r   <= err_b_r;
        end else begin
          cur_b_r <= pid_out;
        end
      end
      S_TGT: begin
        err_r   <= err_a_nxt;
        err_b_r <= err_b_nxt;
      end
      default: ;
    endcase
    if (out_load) begin
      out_cur_a_r <= cur_a_r;
      out_cur_b_r <= cur_b_r;
      out_corr_r  <= corr_r;
      out_unit_r  <= unit_r;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_MAP0)
    else $error("accepted beat did not start the stick mapping");

  a_div_needs_dt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dt_r != '0)
    else $error("divider running with zero dt");

  a_corr_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && pid_sel_r == PID_ANGLE) |=>
      (corr_r <= $signed({1'b0, corr_lim_r}) && corr_r >= -$signed({1'b0, corr_lim_r})))
    else $error("angle correction beyond its limit");

  a_cur_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=>
      (out_cur_a_r <= $signed({1'b0, cur_lim_r}) && out_cur_a_r >= -$signed({1'b0, cur_lim_r})
       && out_cur_b_r <= $signed({1'b0, cur_lim_r})
       && out_cur_b_r >= -$signed({1'b0, cur_lim_r})))
    else $error("drive current beyond its limit");
`endif

endmodule

@@ test/swerve_module_cascaded_pid_tb.sv @@
// Self-checking testbench for the cascaded swerve PID block: directed and random ticks.
module swerve_module_cascaded_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scpid_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AFTER  = 150;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 190;

  typedef struct {
    logic [UNIT_W-1:0]         unit;
    logic signed [STICK_W-1:0] fwd;
    logic signed [STICK_W-1:0] turn;
    logic [DT_W-1:0]           dt;
    logic [ANGLE_W-1:0]        mod_ang;
    logic [ANGLE_W-1:0]        ref_ang;
    logic signed [RPM_W-1:0]   rpm_a;
    logic signed [RPM_W-1:0]   rpm_b;
  } tick_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    s16_t              cur_a;
    s16_t              cur_b;
    s16_t              corr;
  } currents_t;

  // Per-module PID state and gains; predicts the drive currents of every accepted tick.
  class currents_board;
    logic [GAIN_W-1:0] speed_kp, speed_ki, speed_kd;
    logic [GAIN_W-1:0] angle_kp, angle_ki, angle_kd;
    logic [LIM_W-1:0]  cur_lim, corr_lim;
    s16_t angle_integ[UNITS_DEF];
    s16_t angle_prev[UNITS_DEF];
    s16_t speed_integ[2*UNITS_DEF];
    s16_t speed_prev[2*UNITS_DEF];
    currents_t pending_currents[$];
    int errors;
    int checked;
    int ticks;

    function new();
      speed_kp = SPEED_KP_RST;
      speed_ki = SPEED_KI_RST;
      speed_kd = SPEED_KD_RST;
      angle_kp = ANGLE_KP_RST;
      angle_ki = ANGLE_KI_RST;
      angle_kd = ANGLE_KD_RST;
      cur_lim  = CUR_LIM_RST;
      corr_lim = CORR_LIM_RST;
      foreach (angle_integ[i]) begin
        angle_integ[i] = '0;
        angle_prev[i]  = '0;
      end
      foreach (speed_integ[i]) begin
        speed_integ[i] = '0;
        speed_prev[i]  = '0;
      end
      errors  = 0;
      checked = 0;
      ticks   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_SPEED_KP: speed_kp = val;
        REG_SPEED_KI: speed_ki = val;
        REG_SPEED_KD: speed_kd = val;
        REG_ANGLE_KP: angle_kp = val;
        REG_ANGLE_KI: angle_ki = val;
        REG_ANGLE_KD: angle_kd = val;
        REG_CUR_LIM:  cur_lim  = val[LIM_W-1:0];
        REG_CORR_LIM: corr_lim = val[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat_word(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // Deadband, then map -127..127 onto -span/2..span/2, truncating the quotient toward zero.
    function longint stick_speed(logic signed [STICK_W-1:0] v, longint span);
      longint x;
      x = v;
      if (x <= DEADBAND && x >= -DEADBAND) x = 0;
      return (x + 127) * span / 254 - span / 2;
    endfunction

    function longint pid_step(longint err, longint dt, inout s16_t integ, inout s16_t prev,
                              logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                              logic [GAIN_W-1:0] kd, logic [LIM_W-1:0] lim);
      longint deriv;
      longint acc;
      longint q;
      longint lm;
      deriv = 0;
      integ = s16_t'(sat_word(longint'(integ) + err * dt));
      if (dt != 0) deriv = sat_word((err - longint'(prev)) / dt);
      prev = s16_t'(err);
      acc = longint'({32'd0, kp}) * err + longint'({32'd0, ki}) * longint'(integ)
          + longint'({32'd0, kd}) * deriv;
      q  = acc / 64'sd16777216;
      lm = longint'({49'd0, lim});
      if (q > lm) q = lm;
      if (q < -lm) q = -lm;
      return q;
    endfunction

    function void note_tick(tick_t t);
      longint fwd, turn, dt, corr, tgt_a, tgt_b;
      currents_t e;
      int u;
      u     = t.unit % UNITS_DEF;
      fwd   = stick_speed(t.fwd, 600);
      turn  = stick_speed(t.turn, 200);
      dt    = longint'({48'd0, t.dt});
      corr  = pid_step(longint'({55'd0, t.ref_ang}) - longint'({55'd0, t.mod_ang}), dt,
                       angle_integ[u], angle_prev[u], angle_kp, angle_ki, angle_kd, corr_lim);
      tgt_a = sat_word(fwd - turn - corr);
      tgt_b = sat_word(-fwd - turn - corr);
      e.unit  = u;
      e.cur_a = s16_t'(pid_step(sat_word(tgt_a - longint'(t.rpm_a)), dt, speed_integ[2*u],
                                speed_prev[2*u], speed_kp, speed_ki, speed_kd, cur_lim));
      e.cur_b = s16_t'(pid_step(sat_word(tgt_b - longint'(t.rpm_b)), dt, speed_integ[2*u+1],
                                speed_prev[2*u+1], speed_kp, speed_ki, speed_kd, cur_lim));
      e.corr  = s16_t'(corr);
      pending_currents.push_back(e);
      ticks++;
    endfunction

    function void check_currents(logic [UNIT_W-1:0] u, s16_t a, s16_t b, s16_t c);
      currents_t e;
      if (pending_currents.size() == 0) begin
        $display("%0t: unexpected beat unit %0d cur_a %0d cur_b %0d corr %0d",
                 $time, u, a, b, c);
        errors++;
        return;
      end
      e = pending_currents.pop_front();
      checked++;
      if ({u, a, b, c} !== e) begin
        $display("%0t: expected unit %0d cur_a %0d cur_b %0d corr %0d", $time,
                 e.unit, e.cur_a, e.cur_b, e.corr);
        $display("%0t:   actual unit %0d cur_a %0d cur_b %0d corr %0d", $time, u, a, b, c);
        errors++;
      end
    endfunction

    function int pending();
      return pending_currents.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [UNIT_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [UNIT_W-1:0]     out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  currents_board board = new();
  int cycles;
  int burst_left;
  int settings;

  swerve_module_cascaded_pid dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycles, board.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_currents(out_tuser, out_tdata[VAL_W-1:0], out_tdata[2*VAL_W-1:VAL_W],
                           out_tdata[3*VAL_W-1:2*VAL_W]);
  end

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: random stalls, clean stretches, and one long hold-off to back up the input.
  initial begin
    int stall;
    int run_left;
    bit held;
    out_tready = 1'b0;
    stall      = 0;
    run_left   = 0;
    held       = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && board.checked >= HOLD_AFTER) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (run_left > 0) begin
        out_tready = 1'b1;
        run_left--;
      end else if (stall > 0) begin
        out_tready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 99) < 3) begin
        out_tready = 1'b1;
        run_left   = $urandom_range(40, 120);
      end else if ($urandom_range(0, 99) < 30) begin
        out_tready = 1'b0;
        stall      = idle_len() - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic tick_t make_tick(int unit_i, int fwd_i, int turn_i, int dt_i, int mod_i,
                                      int refa_i, int rpma_i, int rpmb_i);
    tick_t t;
    t.unit    = unit_i;
    t.fwd     = fwd_i;
    t.turn    = turn_i;
    t.dt      = dt_i;
    t.mod_ang = mod_i;
    t.ref_ang = refa_i;
    t.rpm_a   = rpma_i;
    t.rpm_b   = rpmb_i;
    return t;
  endfunction

  function automatic logic signed [STICK_W-1:0] rand_stick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 28) - 14;
    if (r < 25) begin
      case ($urandom_range(0, 3))
        0: return -128;
        1: return -127;
        2: return 127;
        default: return 126;
      endcase
    end
    return $urandom_range(0, 255);
  endfunction

  function automatic logic signed [RPM_W-1:0] rand_rpm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 800) - 400;
    if (r < 85) return $urandom_range(0, 8000) - 4000;
    return $urandom_range(0, 65535);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    int r;
    t.unit = $urandom_range(0, UNIT_MAX);
    t.fwd  = rand_stick();
    t.turn = rand_stick();
    r = $urandom_range(0, 99);
    if (r < 10)      t.dt = '0;
    else if (r < 75) t.dt = $urandom_range(1, 30);
    else if (r < 90) t.dt = $urandom_range(31, 1000);
    else             t.dt = $urandom_range(0, 65535);
    t.mod_ang = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 359) : $urandom_range(0, 511);
    t.ref_ang = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 359) : $urandom_range(0, 511);
    t.rpm_a   = rand_rpm();
    t.rpm_b   = rand_rpm();
    return t;
  endfunction

  // Present one tick and hold it until the block takes it; leaves valid high.
  task automatic send_tick(tick_t t);
    in_tdata = '0;
    in_tdata[IN_FWD_LSB  +: STICK_W] = t.fwd;
    in_tdata[IN_TURN_LSB +: STICK_W] = t.turn;
    in_tdata[IN_DT_LSB   +: DT_W]    = t.dt;
    in_tdata[IN_MOD_LSB  +: ANGLE_W] = t.mod_ang;
    in_tdata[IN_REF_LSB  +: ANGLE_W] = t.ref_ang;
    in_tdata[IN_RPMA_LSB +: RPM_W]   = t.rpm_a;
    in_tdata[IN_RPMB_LSB +: RPM_W]   = t.rpm_b;
    in_tuser  = t.unit;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(t);
    @(negedge clk);
  endtask

  task automatic offer(tick_t t);
    int gap;
    send_tick(t);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      burst_left = $urandom_range(20, 60);
    end else if ($urandom_range(0, 99) < 50) begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic settle();
    in_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic load_gains(logic [31:0] skp, logic [31:0] ski, logic [31:0] skd,
                            logic [31:0] akp, logic [31:0] aki, logic [31:0] akd,
                            logic [31:0] cur, logic [31:0] corr);
    settle();
    write_reg(REG_SPEED_KP, skp);
    write_reg(REG_SPEED_KI, ski);
    write_reg(REG_SPEED_KD, skd);
    write_reg(REG_ANGLE_KP, akp);
    write_reg(REG_ANGLE_KI, aki);
    write_reg(REG_ANGLE_KD, akd);
    write_reg(REG_CUR_LIM, cur);
    write_reg(REG_CORR_LIM, corr);
    cfg_valid = 1'b0;
    settings++;
  endtask

  task automatic run_random(int n);
    repeat (n) offer(random_tick());
  endtask

  initial begin
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_SPEED_KP;
    cfg_data   = '0;
    rst_n      = 1'b0;
    burst_left = 0;
    settings   = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed ticks at the reset gains
    offer(make_tick(0, 0, 0, 10, 0, 0, 0, 0));
    offer(make_tick(0, 127, 127, 1, 0, 359, 0, 0));
    offer(make_tick(0, -127, -127, 1, 359, 0, 0, 0));
    offer(make_tick(1, -128, -128, 5, 10, 20, 0, 0));
    offer(make_tick(1, 12, -12, 3, 30, 30, 5, -5));
    offer(make_tick(1, 13, -13, 3, 30, 31, 5, -5));
    offer(make_tick(1, -13, 13, 3, 31, 30, -5, 5));
    // zero elapsed time: derivative zero, integral held
    offer(make_tick(2, 60, -40, 0, 100, 200, 50, -50));
    offer(make_tick(2, 60, -40, 0, 200, 100, -50, 50));
    offer(make_tick(2, 127, -128, 65535, 0, 359, -32768, -32768));
    offer(make_tick(2, 127, -128, 65535, 0, 359, -32768, -32768));
    offer(make_tick(2, -128, 127, 65535, 359, 0, 32767, 32767));
    // angles beyond a full turn pass unwrapped
    offer(make_tick(3, 0, 0, 7, 511, 0, 0, 0));
    offer(make_tick(3, 0, 0, 7, 0, 511, 0, 0));
    offer(make_tick(3, 0, 0, 7, 511, 511, 0, 0));
    offer(make_tick(3, 127, 0, 20, 256, 255, 21845, -21846));
    offer(make_tick(0, 85, -86, 2, 170, 341, -21846, 21845));
    offer(make_tick(0, -86, 85, 1, 341, 170, 32767, -32768));
    offer(make_tick(1, 50, -60, 2, 100, 200, 100, -100));
    offer(make_tick(3, -1, 1, 65535, 1, 0, -1, 1));
    run_random(PHASE_ITEMS);

    load_gains($urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0010_0000),
               $urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0800_0000),
               $urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0100_0000),
               $urandom, $urandom);
    run_random(PHASE_ITEMS);

    // Largest gains and limits; the limit data carries stray upper bits
    load_gains('1, '1, '1, '1, '1, '1, '1, '1);
    run_random(PHASE_ITEMS);

    // Everything zero: outputs clamp to zero
    load_gains('0, '0, '0, '0, '0, '0, '0, '0);
    run_random(PHASE_ITEMS);

    load_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 200), $urandom_range(0, 32767));
    run_random(PHASE_ITEMS);

    load_gains(SPEED_KP_RST, SPEED_KI_RST, SPEED_KD_RST, ANGLE_KP_RST, ANGLE_KI_RST,
               ANGLE_KD_RST, CUR_LIM_RST, CORR_LIM_RST);
    run_random(PHASE_ITEMS);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Drove %0d control ticks for all four modules under %0d gain/limit settings,",
             board.ticks, settings);
    $display("checked %0d current beats, including one %0d-cycle output stall.",
             board.checked, HOLD_CYCLES);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
